// ----- hdl/sha256_message_hasher_assert.svh -----
// Assertion macros for the SHA-256 message hasher.
// Used by the top level only; no other dependencies.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sha_pkg.sv -----
// Package for the SHA-256 message hasher: payload structs, controller states,
// command/status structs, round constants and the round helper functions.
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       final_item;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} sha_state_t;

	// Source of the byte written into the block buffer.
	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LEN
	} sha_src_t;

	typedef struct packed {
		logic       put;       // write one byte at the fill position
		sha_src_t   src;
		logic       add_len;   // count the input byte
		logic       load;      // load working vars from hash words
		logic       round;     // run one compression round
		logic       update;    // fold working vars into hash words
		logic       restart;   // return hash, fill and length to reset values
		logic       emit_next; // advance the digest word pointer
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] round_idx;
		logic [2:0] emit_idx;
	} sha_status_t;

	localparam int unsigned PadFill = 56;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned amt);
		rotr = (v >> amt) | (v << (32 - amt));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] v);
		sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] v);
		sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] v);
		bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] v);
		bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

endpackage

// ----- hdl/sha_ctrl.sv -----
// Controller for the SHA-256 message hasher: sequences byte writes, padding,
// compression rounds and digest output. Depends on sha_pkg.
module sha_ctrl import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  sha_in_t     in_data,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  sha_status_t status,
	output sha_cmd_t    cmd
);

	sha_state_t state_q, state_nxt;
	logic       final_q;    // padding pending for the current message
	logic       in_fire;
	logic       last_put;   // put that completes a block
	logic [3:0] pad_len_q;  // length bytes still to write (8..1), 0 while zero filling
	logic       pad_done_q; // 0x80 already written
	logic       len_done_q; // last length byte written

	assign in_fire = in_valid && in_ready;
	assign last_put = (status.fill == 6'd63);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_data.byte_present && last_put) state_nxt = ST_LOAD;
					else if (in_data.final_item) state_nxt = ST_PAD;
				end
			end
			ST_PAD: begin
				if (last_put) state_nxt = ST_LOAD;
			end
			ST_LOAD: state_nxt = ST_ROUND;
			ST_ROUND: begin
				if (status.round_idx == 6'd63) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!final_q) state_nxt = ST_IDLE;
				else if (len_done_q) state_nxt = ST_EMIT;
				else state_nxt = ST_PAD;
			end
			ST_EMIT: begin
				if (out_ready && status.emit_idx == 3'd7) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.src = SRC_DATA;
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		case (state_q)
			ST_IDLE: begin
				cmd.put = in_fire && in_data.byte_present;
				cmd.add_len = in_fire && in_data.byte_present;
			end
			ST_PAD: begin
				cmd.put = 1'b1;
				if (!pad_done_q) cmd.src = SRC_PAD80;
				else if (pad_len_q != 4'd0) cmd.src = SRC_LEN;
				else cmd.src = SRC_ZERO;
			end
			ST_LOAD:   cmd.load = 1'b1;
			ST_ROUND:  cmd.round = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			ST_EMIT: begin
				cmd.emit_next = out_ready;
				cmd.restart = out_ready && status.emit_idx == 3'd7;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
			pad_done_q <= 1'b0;
			pad_len_q <= 4'd0;
			len_done_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_fire && in_data.final_item) final_q <= 1'b1;
			if (cmd.restart) begin
				final_q <= 1'b0;
				pad_done_q <= 1'b0;
				pad_len_q <= 4'd0;
				len_done_q <= 1'b0;
			end else if (cmd.put && state_q == ST_PAD) begin
				if (!pad_done_q) begin
					pad_done_q <= 1'b1;
					// arm the length when the 0x80 lands right before offset 56
					if (status.fill == 6'(PadFill - 1)) pad_len_q <= 4'd8;
				end else if (pad_len_q != 4'd0) begin
					pad_len_q <= pad_len_q - 4'd1;
					if (pad_len_q == 4'd1) len_done_q <= 1'b1;
				end else if (status.fill == 6'(PadFill - 1)) begin
					pad_len_q <= 4'd8;
				end
			end
		end
	end

endmodule

// ----- hdl/sha_datapath.sv -----
// Datapath for the SHA-256 message hasher: schedule window (which also gathers
// the block bytes), length counter, working variables and hash words. Depends on sha_pkg.
module sha_datapath import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  sha_cmd_t    cmd,
	output sha_status_t status,
	output sha_out_t    out_data
);

	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  rnd_q;
	logic [2:0]  emit_q;
	logic [2:0]  len_ptr_q; // next length byte, big-endian
	logic [7:0]  put_byte;
	logic [31:0] wt, w_new, t1, t2;

	always_comb begin
		case (cmd.src)
			SRC_DATA:  put_byte = data_byte;
			SRC_PAD80: put_byte = 8'h80;
			SRC_ZERO:  put_byte = 8'h00;
			SRC_LEN:   put_byte = len_q[8*(7 - len_ptr_q) +: 8];
			default:   put_byte = 8'h00;
		endcase
	end

	// Window holds W[t..t+15] in w_q[0..15]; w_q[0] is W[t].
	assign wt = w_q[0];
	assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[rnd_q] + wt;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		// gather bytes big-endian straight into the schedule words
		if (cmd.put) w_q[fill_q[5:2]][8*(2'd3 - fill_q[1:0]) +: 8] <= put_byte;
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			emit_q <= '0;
			len_ptr_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
		end else begin
			if (cmd.put) fill_q <= fill_q + 6'd1;
			if (cmd.add_len) len_q <= len_q + 64'd8;
			if (cmd.put && cmd.src == SRC_LEN) len_ptr_q <= len_ptr_q + 3'd1;
			if (cmd.round) rnd_q <= rnd_q + 6'd1;
			if (cmd.update)
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			if (cmd.emit_next) emit_q <= emit_q + 3'd1;
			if (cmd.restart) begin
				len_q <= '0;
				fill_q <= '0;
				len_ptr_q <= '0;
				emit_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
			end
		end
	end

	assign status.fill = fill_q;
	assign status.round_idx = rnd_q;
	assign status.emit_idx = emit_q;
	assign out_data.digest_word = h_q[emit_q];
	assign out_data.word_index = emit_q;
	assign out_data.last_word = (emit_q == 3'd7);

endmodule

// ----- hdl/sha256_message_hasher.sv -----
// Channel | Handshake                | Payload
// in      | in_valid / in_ready      | in_data   (sha_in_t: data_byte, byte_present, final_item)
// out     | out_valid / out_ready    | out_data  (sha_out_t: digest_word, word_index, last_word)
// The 64th byte of a block starts a compression (load, 64 rounds, hash update) on
// the single shared round unit.
// A final item adds padding (one pad byte per cycle) plus one or two compressions,
// then the eight digest words are output. Reset clears hash, fill and length at once.
// in_ready is low while compressing, padding or emitting; out stalls hold the word.
// Top level of the SHA-256 message hasher; depends on sha_pkg, sha_ctrl,
// sha_datapath and sha256_message_hasher_assert.svh.
`include "sha256_message_hasher_assert.svh"
module sha256_message_hasher import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sha_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output sha_out_t out_data
);

	sha_cmd_t    cmd;
	sha_status_t status;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.data_byte(in_data.data_byte),
		.cmd(cmd), .status(status), .out_data(out_data)
	);

	`SHA_ASSERT_IMPL(a_no_overlap, clk, arst_n, in_ready, !out_valid, "input taken while emitting")
	`SHA_ASSERT_IMPL(a_last_idx, clk, arst_n, out_valid && out_data.last_word,
		out_data.word_index == 3'd7, "last word not at index 7")
	`SHA_ASSERT_NEXT(a_restart, clk, arst_n, out_valid && out_ready && out_data.last_word,
		in_ready && status.fill == 6'd0, "no clean restart after digest")

endmodule
